>>> sv/stack_command_interpreter_top_defines.svh
// assertion macros used by the rtl core (sci_core)
`ifndef STACK_COMMAND_INTERPRETER_TOP_DEFINES_SVH
`define STACK_COMMAND_INTERPRETER_TOP_DEFINES_SVH

// same-cycle implication
`define SCI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SCI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/sci_pkg.sv
package sci_pkg;

   localparam int VALUE_W = 31;
   localparam int ERR_W = 3;
   localparam int CHAR_W = 8;
   localparam int ACC_W = VALUE_W + 4;
   localparam int RSP_DATA_W = 40;

   localparam logic [VALUE_W-1:0] VAL_MAX = 31'h7FFF_FFFF;
   localparam logic [ACC_W-1:0] DEC_BASE = 35'd10;

   localparam logic [ERR_W-1:0] ERR_NONE = 3'd0;
   localparam logic [ERR_W-1:0] ERR_UNDER = 3'd1;
   localparam logic [ERR_W-1:0] ERR_NEG = 3'd2;
   localparam logic [ERR_W-1:0] ERR_OVER = 3'd3;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 3'd4;

   localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_DUP = 8'h44;
   localparam logic [CHAR_W-1:0] CH_P = 8'h50;
   localparam logic [CHAR_W-1:0] CH_O = 8'h4F;
   localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;

   typedef struct packed {
      logic valid;
      logic [VALUE_W-1:0] top_value;
      logic [ERR_W-1:0] error_code;
   } res_type;

endpackage

>>> sv/sci_stack_ram.sv
module sci_stack_ram
   import sci_pkg::*;
#(
   parameter int ADDR_W = 6
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem_ff [0:(2**ADDR_W)-1];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // write-first forwarding on a same-row access
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/sci_core.sv
`include "stack_command_interpreter_top_defines.svh"

module sci_core
   import sci_pkg::*;
#(
   parameter int STACK_DEPTH = 128
) (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic [CHAR_W-1:0] char_byte,
   input  logic last_byte,
   output res_type res
);

   localparam int IW = $clog2(STACK_DEPTH);
   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int RAW = (IW > 1) ? IW - 1 : 1;
   localparam logic [DW-1:0] DEPTH_MAX = DW'(STACK_DEPTH);

   logic [VALUE_W-1:0] top_ff, top_in;
   logic [VALUE_W-1:0] sec_ff, sec_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic in_num_ff, in_num_in;
   logic prev_p_ff, prev_p_in;
   logic [ERR_W-1:0] err_ff, err_in;
   logic sel_ff, sel_in;

   logic is_digit, active, digit_ovf, push, push_ovf, cmd_run;
   logic [3:0] digit_val;
   logic [VALUE_W-1:0] acc_base, push_val, t1, s1, refill, pre_value;
   logic [ACC_W-1:0] acc_next;
   logic [VALUE_W:0] sum;
   logic [DW-1:0] d1;
   logic [VALUE_W-1:0] t_n, s_n;
   logic [DW-1:0] d_n;
   logic [ERR_W-1:0] new_err, err_sum, fin_err;
   logic wa_en, wb_en;
   logic [IW-1:0] wa_idx, wb_idx, rd_idx;
   logic [VALUE_W-1:0] wb_data;
   logic w0_en, w1_en;
   logic [RAW-1:0] w0_row, w1_row, rd_row;
   logic [VALUE_W-1:0] w0_data, w1_data, rd0_data, rd1_data;

   always_comb begin
      is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
      digit_val = 4'(char_byte - CH_ZERO);
      active = (err_ff == ERR_NONE);
      acc_base = in_num_ff ? acc_ff : '0;
      acc_next = ACC_W'(acc_base) * DEC_BASE + ACC_W'(digit_val);
      digit_ovf = (acc_next > ACC_W'(VAL_MAX));

      push = active && (is_digit ? (last_byte && !digit_ovf) : in_num_ff);
      push_val = is_digit ? acc_next[VALUE_W-1:0] : acc_ff;
      push_ovf = push && (depth_ff == DEPTH_MAX);
      cmd_run = active && !is_digit && !push_ovf;

      t1 = push ? push_val : top_ff;
      s1 = push ? top_ff : sec_ff;
      d1 = push ? depth_ff + DW'(1) : depth_ff;
      refill = push ? sec_ff : pre_value;
      sum = {1'b0, t1} + {1'b0, s1};

      wa_en = push && !push_ovf && (depth_ff >= DW'(2));
      wa_idx = IW'(depth_ff - DW'(2));
      wb_en = 1'b0;
      wb_idx = IW'(d1 - DW'(2));
      wb_data = s1;

      new_err = ERR_NONE;
      t_n = t1;
      s_n = s1;
      d_n = d1;

      if (active && is_digit && digit_ovf) begin
         new_err = ERR_OVER;
      end else if (push_ovf) begin
         new_err = ERR_OVER;
      end else if (cmd_run) begin
         case (char_byte)
            CH_PLUS: begin
               if (d1 < DW'(2)) begin
                  new_err = ERR_UNDER;
               end else if (sum[VALUE_W]) begin
                  new_err = ERR_OVER;
               end else begin
                  t_n = sum[VALUE_W-1:0];
                  s_n = refill;
                  d_n = d1 - DW'(1);
               end
            end
            CH_MINUS: begin
               if (d1 < DW'(2)) begin
                  new_err = ERR_UNDER;
               end else if (t1 < s1) begin
                  new_err = ERR_NEG;
               end else begin
                  t_n = t1 - s1;
                  s_n = refill;
                  d_n = d1 - DW'(1);
               end
            end
            CH_DUP: begin
               if (d1 == '0) begin
                  new_err = ERR_UNDER;
               end else if (d1 == DEPTH_MAX) begin
                  new_err = ERR_OVER;
               end else begin
                  s_n = t1;
                  d_n = d1 + DW'(1);
                  wb_en = (d1 >= DW'(2));
               end
            end
            CH_O: begin
               if (prev_p_ff) begin
                  if (d1 == '0) begin
                     new_err = ERR_UNDER;
                  end else begin
                     t_n = s1;
                     s_n = refill;
                     d_n = d1 - DW'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end

      err_sum = active ? new_err : err_ff;
      fin_err = err_sum;
      if ((err_sum == ERR_NONE) && (d_n == '0)) begin
         fin_err = ERR_EMPTY;
      end

      top_in = top_ff;
      sec_in = sec_ff;
      depth_in = depth_ff;
      acc_in = acc_ff;
      in_num_in = in_num_ff;
      prev_p_in = prev_p_ff;
      err_in = err_ff;
      res.valid = accept && last_byte;
      res.error_code = fin_err;
      res.top_value = (fin_err == ERR_NONE) ? t_n : '0;

      if (accept) begin
         if (last_byte) begin
            depth_in = '0;
            acc_in = '0;
            in_num_in = 1'b0;
            prev_p_in = 1'b0;
            err_in = ERR_NONE;
         end else begin
            err_in = err_sum;
            if (active && (new_err == ERR_NONE)) begin
               top_in = t_n;
               sec_in = s_n;
               depth_in = d_n;
               if (is_digit) begin
                  acc_in = acc_next[VALUE_W-1:0];
                  in_num_in = 1'b1;
                  prev_p_in = 1'b0;
               end else begin
                  in_num_in = 1'b0;
                  prev_p_in = (char_byte == CH_P);
               end
            end
         end
      end

      // spills land in different banks when both occur
      w0_en = accept && ((wa_en && !wa_idx[0]) || (wb_en && !wb_idx[0]));
      w1_en = accept && ((wa_en && wa_idx[0]) || (wb_en && wb_idx[0]));
      w0_row = (wa_en && !wa_idx[0]) ? RAW'(wa_idx >> 1) : RAW'(wb_idx >> 1);
      w1_row = (wa_en && wa_idx[0]) ? RAW'(wa_idx >> 1) : RAW'(wb_idx >> 1);
      w0_data = (wa_en && !wa_idx[0]) ? sec_ff : wb_data;
      w1_data = (wa_en && wa_idx[0]) ? sec_ff : wb_data;

      // prefetch the entry just below the second register
      rd_idx = IW'(depth_in - DW'(3));
      rd_row = RAW'(rd_idx >> 1);
      sel_in = rd_idx[0];
      pre_value = sel_ff ? rd1_data : rd0_data;
   end

   sci_stack_ram #(.ADDR_W(RAW)) u_bank0 (
      .clock   (clock),
      .wr_en   (w0_en),
      .wr_addr (w0_row),
      .wr_data (w0_data),
      .rd_addr (rd_row),
      .rd_data (rd0_data)
   );

   sci_stack_ram #(.ADDR_W(RAW)) u_bank1 (
      .clock   (clock),
      .wr_en   (w1_en),
      .wr_addr (w1_row),
      .wr_data (w1_data),
      .rd_addr (rd_row),
      .rd_data (rd1_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         acc_ff <= '0;
         in_num_ff <= 1'b0;
         prev_p_ff <= 1'b0;
         err_ff <= ERR_NONE;
         sel_ff <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         acc_ff <= acc_in;
         in_num_ff <= in_num_in;
         prev_p_ff <= prev_p_in;
         err_ff <= err_in;
         sel_ff <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      sec_ff <= sec_in;
   end

   `SCI_ASSERT_SAME(a_depth_bound, clock, reset, 1'b1, depth_ff <= DEPTH_MAX, "depth above capacity")
   `SCI_ASSERT_NEXT(a_clear_after_last, clock, reset, accept && last_byte, (depth_ff == '0) && (err_ff == ERR_NONE) && !in_num_ff, "state not cleared after last byte")
   `SCI_ASSERT_NEXT(a_error_freezes, clock, reset, (err_ff != ERR_NONE) && !(accept && last_byte), (err_ff == $past(err_ff)) && (depth_ff == $past(depth_ff)), "state moved after an error")
   `SCI_ASSERT_SAME(a_error_zero_top, clock, reset, res.valid && (res.error_code != ERR_NONE), res.top_value == '0, "nonzero top with error")
   `SCI_ASSERT_SAME(a_spill_banks, clock, reset, accept && wa_en && wb_en, wa_idx[0] != wb_idx[0], "two spills in one bank")

endmodule

>>> sv/sci_out_buf.sv
module sci_out_buf
   import sci_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  res_type res,
   output logic in_ready,
   output logic out_valid,
   input  logic out_ready,
   output logic [VALUE_W-1:0] out_top_value,
   output logic [ERR_W-1:0] out_error_code
);

   logic out_valid_ff, out_valid_in;
   logic skid_valid_ff, skid_valid_in;
   res_type out_data_ff, out_data_in;
   res_type skid_data_ff, skid_data_in;
   logic advance;

   always_comb begin
      advance = !out_valid_ff || out_ready;
      out_valid_in = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in = out_data_ff;
      skid_data_in = skid_data_ff;
      if (advance) begin
         if (skid_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res.valid;
            out_data_in = res;
         end
      end else if (res.valid) begin
         skid_valid_in = 1'b1;
         skid_data_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_top_value = out_data_ff.top_value;
   assign out_error_code = out_data_ff.error_code;

endmodule

>>> sv/stack_command_interpreter_top.sv
// stack command interpreter
// req channel: one command byte per word, req_tlast marks the last byte of
// a string. digits build a number, '+' '-' 'D' and the pair 'P' 'O' act on
// the value stack, any other byte just ends a number.
// rsp channel: one word per string, sent for its last byte, with the top of
// stack and an error code (0 ok, 1 underflow, 2 negative difference,
// 3 overflow, 4 empty at end); the top value is 0 whenever the code is not 0.
// throughput: one byte per cycle while req_tready is high. the top two
// entries live in registers and the rest in two banked memories (even
// and odd entries) with a registered prefetch of the next entry down,
// so no command waits on a memory read. each result word is registered.
// after the last byte the interpreter is back at an empty stack, ready for
// the next string in the next cycle.
// reset clears all control state; no memory clearing pass is needed.
// a stalled receiver: one result waits on rsp and a second one is held in a
// skid register; req_tready drops only while that skid register is full.
module stack_command_interpreter_top
   import sci_pkg::*;
#(
   parameter int STACK_DEPTH = 128
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,                // char_byte
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata      // top_value, error_code
);

   logic accept;
   res_type res;
   logic [VALUE_W-1:0] out_top_value;
   logic [ERR_W-1:0] out_error_code;

   assign accept = req_tvalid && req_tready;

   sci_core #(.STACK_DEPTH(STACK_DEPTH)) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_byte (req_tdata),
      .last_byte (req_tlast),
      .res       (res)
   );

   sci_out_buf u_out_buf (
      .clock          (clock),
      .reset          (reset),
      .res            (res),
      .in_ready       (req_tready),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_top_value  (out_top_value),
      .out_error_code (out_error_code)
   );

   assign rsp_tdata = {(RSP_DATA_W - VALUE_W - ERR_W)'(0), out_error_code, out_top_value};

endmodule

>>> sim/stack_command_interpreter_checker.sv
`timescale 1ns / 1ps

module stack_command_interpreter_checker
   import sci_pkg::*;
#(
   parameter int STACK_DEPTH = 128
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [7:0] req_tdata,
   input  logic req_tlast,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int unsigned fail_count,
   output int unsigned pending
);

   typedef struct packed {
      logic [VALUE_W-1:0] top;
      logic [ERR_W-1:0] code;
   } outcome_type;

   logic [VALUE_W-1:0] vstack [STACK_DEPTH];
   int unsigned depth;
   logic [VALUE_W-1:0] accum;
   bit in_num;
   bit prev_p;
   logic [ERR_W-1:0] err;

   outcome_type outcomes_due [$];
   int unsigned mismatches = 0;

   function automatic void clear_state();
      depth = 0;
      accum = '0;
      in_num = 0;
      prev_p = 0;
      err = ERR_NONE;
   endfunction

   function automatic void raise(input logic [ERR_W-1:0] code);
      if (err == ERR_NONE) begin
         err = code;
      end
   endfunction

   function automatic void push_entry(input logic [VALUE_W-1:0] v);
      if (depth >= STACK_DEPTH) begin
         raise(ERR_OVER);
         return;
      end
      vstack[depth] = v;
      depth++;
   endfunction

   function automatic void run_command(input logic [7:0] c);
      logic [VALUE_W-1:0] a;
      logic [VALUE_W-1:0] b;
      logic [VALUE_W:0] sum;
      if (c == CH_PLUS || c == CH_MINUS) begin
         if (depth < 2) begin
            raise(ERR_UNDER);
            return;
         end
         a = vstack[depth-1];
         b = vstack[depth-2];
         if (c == CH_PLUS) begin
            sum = {1'b0, a} + {1'b0, b};
            if (sum[VALUE_W]) begin
               raise(ERR_OVER);
               return;
            end
            vstack[depth-2] = sum[VALUE_W-1:0];
         end else begin
            if (a < b) begin
               raise(ERR_NEG);
               return;
            end
            vstack[depth-2] = a - b;
         end
         depth--;
      end else if (c == CH_DUP) begin
         if (depth == 0) begin
            raise(ERR_UNDER);
            return;
         end
         push_entry(vstack[depth-1]);
      end else if (c == CH_O && prev_p) begin
         if (depth == 0) begin
            raise(ERR_UNDER);
            return;
         end
         depth--;
      end
   endfunction

   function automatic void take_char(input logic [7:0] c);
      logic [ACC_W-1:0] nxt;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         if (!in_num) begin
            accum = '0;
            in_num = 1;
         end
         nxt = {{(ACC_W-VALUE_W){1'b0}}, accum} * 35'd10 + ACC_W'(c - CH_ZERO);
         if (nxt > ACC_W'(VAL_MAX)) begin
            raise(ERR_OVER);
            return;
         end
         accum = nxt[VALUE_W-1:0];
         prev_p = 0;
         return;
      end
      if (in_num) begin
         in_num = 0;
         push_entry(accum);
         if (err != ERR_NONE) begin
            return;
         end
      end
      run_command(c);
      prev_p = (c == CH_P);
   endfunction

   // returns 1 when the byte closes a string and yields a result word
   function automatic bit interpret_byte(input logic [7:0] c, input bit last,
                                         output outcome_type res);
      res = '0;
      if (err == ERR_NONE) begin
         take_char(c);
      end
      if (!last) begin
         return 0;
      end
      if (err == ERR_NONE && in_num) begin
         in_num = 0;
         push_entry(accum);
      end
      if (err == ERR_NONE && depth == 0) begin
         raise(ERR_EMPTY);
      end
      res.code = err;
      res.top = (err == ERR_NONE) ? vstack[depth-1] : '0;
      clear_state();
      return 1;
   endfunction

   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (reset) begin
         clear_state();
         outcomes_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.top = rsp_tdata[VALUE_W-1:0];
            got.code = rsp_tdata[VALUE_W+ERR_W-1:VALUE_W];
            if (outcomes_due.size() == 0) begin
               if (mismatches < 10) begin
                  $display("unexpected result word: top %0d code %0d", got.top, got.code);
               end
               mismatches++;
            end else begin
               want = outcomes_due.pop_front();
               if (got.top !== want.top || got.code !== want.code) begin
                  if (mismatches < 10) begin
                     $display("result mismatch: expected top %0d code %0d, got top %0d code %0d",
                              want.top, want.code, got.top, got.code);
                  end
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (interpret_byte(req_tdata, req_tlast, want)) begin
               outcomes_due.push_back(want);
            end
         end
      end
      pending <= outcomes_due.size();
      fail_count <= mismatches;
   end

endmodule

>>> sim/stack_command_interpreter_top_test.sv
`timescale 1ns / 1ps

module stack_command_interpreter_top_test
   import sci_pkg::*;
;

   localparam int DEPTH = 128;
   localparam int ITEMS = 1500;
   localparam int CALM_ITEMS = 250;
   localparam int LONG_HOLD = 400;
   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;
   logic req_tlast;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned sent = 0;
   int unsigned holds_asked = 0;
   int unsigned holds_done = 0;
   int unsigned cycles = 0;
   bit calm = 0;
   bit gappy = 0;
   logic [7:0] cmd_bytes [$];

   stack_command_interpreter_top #(
      .STACK_DEPTH(DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   stack_command_interpreter_checker #(
      .STACK_DEPTH(DEPTH)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         cmd_bytes.push_back(s[i]);
      end
   endtask

   function automatic string number_text();
      case ($urandom_range(0, 11))
         0: return $sformatf("%0d", VAL_MAX);
         1: return "2147483648";
         2: return $sformatf("%0d%0d", $urandom_range(1, 9), $urandom_range(0, 999999999));
         3: return $sformatf("%0d", $urandom_range(0, 32'h7FFF_FFFF));
         4: return $sformatf("0%0d", $urandom_range(0, 99));
         5: return $sformatf("%0d", $urandom_range(0, 99999));
         default: return $sformatf("%0d", $urandom_range(0, 99));
      endcase
   endfunction

   task automatic add_op();
      case ($urandom_range(0, 5))
         0, 1: cmd_bytes.push_back(CH_PLUS);
         2: cmd_bytes.push_back(CH_MINUS);
         3: cmd_bytes.push_back(CH_DUP);
         4: begin
            cmd_bytes.push_back(CH_P);
            cmd_bytes.push_back(CH_O);
         end
         default: cmd_bytes.push_back(CH_P);
      endcase
   endtask

   // numbers with operators between them, mostly well formed
   task automatic make_program();
      int nums;
      nums = $urandom_range(1, 6);
      for (int k = 0; k < nums; k++) begin
         add_text(number_text());
         if (k > 0 && $urandom_range(0, 2) != 0) begin
            add_op();
         end else begin
            cmd_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'h2C : 8'h20);
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         add_op();
      end
   endtask

   // fills the stack to around its full depth
   task automatic make_deep();
      int fill;
      fill = $urandom_range(DEPTH - 3, DEPTH + 2);
      add_text(number_text());
      for (int k = 1; k < fill; k++) begin
         cmd_bytes.push_back(CH_DUP);
      end
      if ($urandom_range(0, 1) == 0) begin
         add_text(" 5");
      end
      for (int k = $urandom_range(0, 4); k > 0; k--) begin
         cmd_bytes.push_back(CH_PLUS);
      end
   endtask

   task automatic make_noise();
      for (int k = $urandom_range(1, 8); k > 0; k--) begin
         cmd_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input bit last);
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sent++;
   endtask

   task automatic send_string();
      for (int i = 0; i < cmd_bytes.size(); i++) begin
         if (gappy && !calm && $urandom_range(0, 4) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         send_byte(cmd_bytes[i], i == cmd_bytes.size() - 1);
      end
      cmd_bytes.delete();
   endtask

   task automatic send_fixed(input string s);
      add_text(s);
      send_string();
   endtask

   // receiver: random stall bursts, plus one long hold on request
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_asked != holds_done) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(0, 24)) @(posedge clock);
         end
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      bit held;
      bit paused;
      held = 0;
      paused = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_fixed("+");
      cmd_bytes.push_back(8'h00);
      send_string();
      send_fixed("PO");
      send_fixed("D");
      send_fixed("3 4+");
      send_fixed("9 3-");
      send_fixed("7DPO");
      send_fixed("P5O");
      cmd_bytes.push_back(8'hFF);
      send_fixed("0");

      while (sent < ITEMS) begin
         gappy = ($urandom_range(0, 1) == 0);
         calm = (sent > ITEMS - CALM_ITEMS);
         case ($urandom_range(0, 39))
            0, 1, 2, 3: make_noise();
            4: make_deep();
            5, 6, 7: begin
               make_program();
               cmd_bytes[$urandom_range(0, cmd_bytes.size() - 1)] = 8'($urandom_range(0, 255));
            end
            8: begin
               add_op();
               make_program();
            end
            default: make_program();
         endcase
         send_string();
         if (!held && sent >= 400) begin
            held = 1;
            holds_asked++;
         end
         if (!paused && sent >= 900) begin
            paused = 1;
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending != 0) begin
               @(posedge clock);
            end
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
